FILE: hw/rtl/ide_pkg.sv
// Package for the indexed deque engine: operation and status codes,
// controller states, and the command and status structs between the units.
// Depends on nothing.
`timescale 1ns / 1ps

package ide_pkg;

   // Field widths of the request and response words.
   localparam int MODE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 3;
   localparam int OCC_W    = 7;
   localparam int REQ_W    = 48;
   localparam int RSP_W    = 48;
   localparam int MASK_W   = 32;

   // Bit offsets inside the request word, lowest field first.
   localparam int REQ_MODE_LO  = 0;
   localparam int REQ_VALUE_LO = REQ_MODE_LO + MODE_W;
   localparam int REQ_POS_LO   = REQ_VALUE_LO + VALUE_W;

   // Bit offsets inside the response word, lowest field first.
   localparam int RSP_STATUS_LO = 0;
   localparam int RSP_DATA_LO   = RSP_STATUS_LO + STATUS_W;
   localparam int RSP_OCC_LO    = RSP_DATA_LO + VALUE_W;

   typedef enum logic [MODE_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_WRITE_AT   = 3'd4,
      OP_READ_AT    = 3'd5,
      OP_SEARCH     = 3'd6,
      OP_NOP        = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_BADPOS   = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_SCAN,
      S_FINISH
   } ctl_state_type;

   // Which ring slot the memory port addresses this cycle.
   typedef enum logic [2:0] {
      A_FRONT_DEC,
      A_BACK,
      A_FRONT,
      A_LAST,
      A_POS,
      A_SCAN
   } addr_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         capture;
      logic         mem_wr;
      logic         mem_rd;
      addr_sel_type addr_sel;
      logic         front_dec;
      logic         front_inc;
      logic         cnt_inc;
      logic         cnt_dec;
      logic         res_wr;
      status_type   res_status;
      logic         res_take_rd;
      logic         scan_clr;
      logic         scan_issue;
      logic         out_load;
   } ide_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      logic   full;
      logic   empty;
      logic   pos_bad;
      logic   scan_hit;
      logic   scan_more;
      logic   out_free;
   } ide_stat_type;

endpackage

FILE: hw/rtl/ide_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module ide_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/ide_ctrl.sv
// Controller state machine of the indexed deque engine.
// Depends on ide_pkg; drives the datapath through ide_cmd_type.
`timescale 1ns / 1ps

module ide_ctrl
   import ide_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  ide_stat_type stat,
   output ide_cmd_type  cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (stat.op)
               OP_POP_FRONT, OP_POP_BACK: begin
                  state_in = stat.empty ? S_FINISH : S_READ;
               end
               OP_READ_AT: begin
                  state_in = stat.pos_bad ? S_FINISH : S_READ;
               end
               OP_SEARCH: begin
                  state_in = S_SCAN;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_READ: begin
            state_in = S_FINISH;
         end
         S_SCAN: begin
            if (stat.scan_hit || !stat.scan_more) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs: handshake and datapath commands.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // No request is taken while reset is held.
            req_tready  = !reset;
            cmd.capture = req_tvalid && !reset;
         end
         S_EXEC: begin
            cmd.res_wr     = 1'b1;
            cmd.res_status = ST_OK;
            case (stat.op)
               OP_PUSH_FRONT: begin
                  if (stat.full) begin
                     cmd.res_status = ST_FULL;
                  end else begin
                     cmd.mem_wr    = 1'b1;
                     cmd.addr_sel  = A_FRONT_DEC;
                     cmd.front_dec = 1'b1;
                     cmd.cnt_inc   = 1'b1;
                  end
               end
               OP_PUSH_BACK: begin
                  if (stat.full) begin
                     cmd.res_status = ST_FULL;
                  end else begin
                     cmd.mem_wr   = 1'b1;
                     cmd.addr_sel = A_BACK;
                     cmd.cnt_inc  = 1'b1;
                  end
               end
               OP_POP_FRONT: begin
                  if (stat.empty) begin
                     cmd.res_status = ST_EMPTY;
                  end else begin
                     cmd.res_wr    = 1'b0;
                     cmd.mem_rd    = 1'b1;
                     cmd.addr_sel  = A_FRONT;
                     cmd.front_inc = 1'b1;
                     cmd.cnt_dec   = 1'b1;
                  end
               end
               OP_POP_BACK: begin
                  if (stat.empty) begin
                     cmd.res_status = ST_EMPTY;
                  end else begin
                     cmd.res_wr   = 1'b0;
                     cmd.mem_rd   = 1'b1;
                     cmd.addr_sel = A_LAST;
                     cmd.cnt_dec  = 1'b1;
                  end
               end
               OP_WRITE_AT: begin
                  if (stat.pos_bad) begin
                     cmd.res_status = ST_BADPOS;
                  end else begin
                     cmd.mem_wr   = 1'b1;
                     cmd.addr_sel = A_POS;
                  end
               end
               OP_READ_AT: begin
                  if (stat.pos_bad) begin
                     cmd.res_status = ST_BADPOS;
                  end else begin
                     cmd.res_wr   = 1'b0;
                     cmd.mem_rd   = 1'b1;
                     cmd.addr_sel = A_POS;
                  end
               end
               OP_SEARCH: begin
                  cmd.res_wr   = 1'b0;
                  cmd.scan_clr = 1'b1;
               end
               default: begin
                  cmd.res_status = ST_OK;
               end
            endcase
         end
         S_READ: begin
            cmd.res_wr      = 1'b1;
            cmd.res_status  = ST_OK;
            cmd.res_take_rd = 1'b1;
         end
         S_SCAN: begin
            // Compare the element read last cycle while the next read goes out.
            if (stat.scan_hit) begin
               cmd.res_wr      = 1'b1;
               cmd.res_status  = ST_OK;
               cmd.res_take_rd = 1'b1;
            end else if (!stat.scan_more) begin
               cmd.res_wr     = 1'b1;
               cmd.res_status = ST_NOTFOUND;
            end else begin
               cmd.mem_rd     = 1'b1;
               cmd.addr_sel   = A_SCAN;
               cmd.scan_issue = 1'b1;
            end
         end
         S_FINISH: begin
            cmd.out_load = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: hw/rtl/ide_datapath.sv
// Datapath of the indexed deque engine: request capture, ring pointers,
// ring store, search compare, result and response registers.
// Depends on ide_pkg and ide_ram.
`timescale 1ns / 1ps

module ide_datapath
   import ide_pkg::*;
#(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_valid,
   input  logic [MASK_W-1:0] csr_data,
   input  ide_cmd_type      cmd,
   output ide_stat_type     stat
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = IDX_W + 1;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Captured request.
   op_type               mode_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic [POS_W-1:0]     pos_ff;

   // Ring pointers, mask and scan state.
   logic [IDX_W-1:0]     front_ff, front_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [MASK_W-1:0]    mask_ff;
   logic [CNT_W-1:0]     scan_idx_ff, scan_idx_in;
   logic                 rd_valid_ff;

   // Result and response registers.
   status_type           res_status_ff;
   logic [DATA_W-1:0]    res_data_ff, res_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff;
   logic [DATA_W-1:0]    rsp_data_ff;
   logic [CNT_W-1:0]     rsp_count_ff;

   logic [IDX_W-1:0]     front_dec;
   logic [IDX_W-1:0]     front_inc;
   logic [CNT_W-1:0]     count_m1;
   logic [IDX_W-1:0]     offset;
   logic [SUM_W-1:0]     slot_sum;
   logic [IDX_W-1:0]     mem_addr;
   logic [DATA_W-1:0]    val_elem;
   logic [DATA_W-1:0]    mask_elem;
   logic [DATA_W-1:0]    rd_data;

   assign val_elem  = DATA_W'(value_ff);
   assign mask_elem = DATA_W'(mask_ff);
   assign count_m1  = count_ff - CNT_W'(1);

   // Pointer steps with wrap at the ring end.
   assign front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - IDX_W'(1);
   assign front_inc = (front_ff == IDX_W'(DEPTH - 1)) ? '0 : front_ff + IDX_W'(1);

   // Offset from the front element for the selected access.
   always_comb begin
      case (cmd.addr_sel)
         A_BACK:  offset = count_ff[IDX_W-1:0];
         A_LAST:  offset = count_m1[IDX_W-1:0];
         A_POS:   offset = IDX_W'(pos_ff);
         A_SCAN:  offset = scan_idx_ff[IDX_W-1:0];
         default: offset = '0;
      endcase
   end

   // Ring slot: front plus offset, folded once at the ring size.
   assign slot_sum = {1'b0, front_ff} + {1'b0, offset};

   always_comb begin
      if (cmd.addr_sel == A_FRONT_DEC) begin
         mem_addr = front_dec;
      end else if (slot_sum >= SUM_W'(DEPTH)) begin
         mem_addr = IDX_W'(slot_sum - SUM_W'(DEPTH));
      end else begin
         mem_addr = slot_sum[IDX_W-1:0];
      end
   end

   ide_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.mem_wr),
      .wr_addr (mem_addr),
      .wr_data (val_elem),
      .rd_en   (cmd.mem_rd),
      .rd_addr (mem_addr),
      .rd_data (rd_data)
   );

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= op_type'(req_tdata[REQ_MODE_LO +: MODE_W]);
         value_ff <= req_tdata[REQ_VALUE_LO +: VALUE_W];
         pos_ff   <= req_tdata[REQ_POS_LO +: POS_W];
      end
   end

   // Next values of the pointers and the scan index.
   always_comb begin
      front_in = front_ff;
      if (cmd.front_dec) begin
         front_in = front_dec;
      end else if (cmd.front_inc) begin
         front_in = front_inc;
      end

      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_m1;
      end

      scan_idx_in = scan_idx_ff;
      if (cmd.scan_clr) begin
         scan_idx_in = '0;
      end else if (cmd.scan_issue) begin
         scan_idx_in = scan_idx_ff + CNT_W'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         mask_ff      <= '1;
         scan_idx_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         scan_idx_ff  <= scan_idx_in;
         rd_valid_ff  <= cmd.scan_issue;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            mask_ff <= csr_data;
         end
      end
   end

   // Result staging: data is the read element or zero.
   assign res_data_in = cmd.res_take_rd ? rd_data : '0;

   always_ff @(posedge clock) begin
      if (cmd.res_wr) begin
         res_status_ff <= cmd.res_status;
         res_data_ff   <= res_data_in;
      end
   end

   // Response register; it frees when the receiver takes the response.
   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_data_ff   <= res_data_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {
      {(RSP_W - OCC_W - VALUE_W - STATUS_W){1'b0}},
      OCC_W'(rsp_count_ff),
      VALUE_W'(rsp_data_ff),
      rsp_status_ff
   };

   // Status toward the controller.
   always_comb begin
      stat.op        = mode_ff;
      stat.full      = (count_ff == CNT_W'(DEPTH));
      stat.empty     = (count_ff == '0);
      stat.pos_bad   = (CMP_W'(pos_ff) >= CMP_W'(count_ff));
      stat.scan_hit  = rd_valid_ff && (((rd_data ^ val_elem) & mask_elem) == '0);
      stat.scan_more = (scan_idx_ff < count_ff);
      stat.out_free  = ~rsp_valid_ff | rsp_tready;
   end

endmodule

FILE: hw/rtl/indexed_deque_engine.sv
// Top level of the indexed deque engine: controller plus datapath.
// Depends on ide_pkg, ide_ctrl, ide_datapath and ide_ram.
//
// A bounded double-ended queue of DATA_W-bit elements kept in a ring RAM of
// DEPTH entries. Each request on the req_ stream carries an operation (push
// front/back, pop front/back, write at, read at, search), a value and a
// position; each request yields exactly one response on the rsp_ stream with
// a status, the element (zero unless one was popped, read or found) and the
// occupancy after the operation. The csr_ channel writes the search key mask;
// write it only while no request is in flight.
// Timing: the engine works on one request at a time. A push, write at, or a
// rejected operation passes through the execute and finish states, and the next
// request is taken once the controller is back in idle. Pop and read at add a
// read state for the registered RAM read. Search issues one RAM read a cycle and
// compares each element in the cycle after its read; the response follows once a
// match is found or every occupied entry has been compared against the key.
// Reset empties the queue and sets the key mask to all ones; the RAM is not
// cleared. A stalled response waits in an output register while the engine
// finishes one more request at most, then holds that result and takes no other.
`timescale 1ns / 1ps

module indexed_deque_engine
   import ide_pkg::*;
#(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              reset,
   // Request: mode [2:0], value [34:3], position [40:35], zero padding above.
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,
   // Response: status [2:0], data [34:3], occupancy [41:35], zero padding above.
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,
   // Key mask write.
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [MASK_W-1:0] csr_data
);

   ide_cmd_type  cmd;
   ide_stat_type stat;

   // The mask register takes a write in any cycle out of reset.
   assign csr_ready = ~reset;

   ide_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ide_datapath #(
      .DEPTH  (DEPTH),
      .DATA_W (DATA_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

FILE: hw/rtl/ide_checker.sv
// Port-level checks of the indexed deque engine, bound to the top level.
// Depends on ide_pkg and indexed_deque_engine.
`timescale 1ns / 1ps

module ide_port_checker
   import ide_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   logic [STATUS_W-1:0] rsp_status;
   logic [VALUE_W-1:0]  rsp_data;
   logic [OCC_W-1:0]    rsp_occ;

   assign rsp_status = rsp_tdata[RSP_STATUS_LO +: STATUS_W];
   assign rsp_data   = rsp_tdata[RSP_DATA_LO +: VALUE_W];
   assign rsp_occ    = rsp_tdata[RSP_OCC_LO +: OCC_W];

   // A stalled response stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response withdrawn while stalled");

   // A stalled response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response payload changed while stalled");

   // Any status other than ok carries zero data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status != ST_OK) |-> (rsp_data == '0))
      else $error("failed operation returned data");

   // Occupancy never exceeds the ring size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (DEPTH >= (1 << OCC_W)) || (int'(rsp_occ) <= DEPTH))
      else $error("occupancy above ring size");

   // Occupancy moves by at most one between back-to-back responses.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready ##1 rsp_tvalid |->
         (rsp_occ == $past(rsp_occ)) || (rsp_occ == $past(rsp_occ) + OCC_W'(1)) ||
         (rsp_occ == $past(rsp_occ) - OCC_W'(1)))
      else $error("occupancy jumped between responses");

endmodule

bind indexed_deque_engine ide_port_checker #(
   .DEPTH (DEPTH)
) u_ide_port_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
